// File: sv/pewm_pkg.sv
// shared types and constants for the priority error word unit
// no dependencies; used by pewm_cell and the top level
`default_nettype none

package pewm_pkg;

    localparam int unsigned CODE_W = 8;

    typedef logic [CODE_W-1:0] t_code;

    // operation codes carried on the op field
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // history row control, shared by every cell
    typedef struct packed {
        logic push;   // shift one place toward the oldest entry
        logic clear;  // zero this entry instead of taking the neighbor's value
    } t_hist_ctrl;

endpackage : pewm_pkg

`default_nettype wire

// File: sv/pewm_cell.sv
// one history entry of the sent-code row: holds a code, compares it with the probe,
// hands its code to the next cell on a push. depends on pewm_pkg
`default_nettype none

module pewm_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pewm_pkg::t_hist_ctrl i_ctrl,
    input  pewm_pkg::t_code     i_shift_in,
    input  pewm_pkg::t_code     i_probe,
    output pewm_pkg::t_code     o_entry,
    output logic                o_match
);

    pewm_pkg::t_code r_entry;
    pewm_pkg::t_code n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            n_entry = i_ctrl.clear ? '0 : i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_probe);

endmodule : pewm_cell

`default_nettype wire

// File: sv/priority_error_word_with_recent_mask_unit.sv
// top level of the priority error word unit with a recently-sent mask
// instantiates a row of pewm_cell history entries; depends on pewm_pkg
`default_nettype none

// Collects error codes and hands out one telemetry error word per poll. A report
// transaction (op = 0) with a nonzero code is compared with the last HISTORY_DEPTH
// codes sent; a code not in that history competes for the best unmasked code, one
// that is in it competes for the best masked code, and the lower nonzero code wins.
// A poll transaction (op = 1) returns the best unmasked code and pushes it into the
// history, or else the best masked code after emptying the history, or 0 if neither
// is pending; any nonzero word clears both trackers. Reports give no result, each
// poll gives exactly one. The history is a row of cells that all compare against
// the incoming code at once and shift in step, so a new transaction is taken in
// every cycle while the output register is free or being taken. The input stalls
// only while a poll result waits and the output is stalled.

module priority_error_word_with_recent_mask_unit #(
    parameter int unsigned HISTORY_DEPTH = 10
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input channel
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_op,
    input  wire [pewm_pkg::CODE_W-1:0] i_error_id,
    // output channel
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [pewm_pkg::CODE_W-1:0] o_telem_word
);

    // handshake
    logic w_in_acc;
    logic w_out_acc;

    // history row
    pewm_pkg::t_code w_entry [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] w_match;
    logic w_hit;
    pewm_pkg::t_hist_ctrl w_ctrl_head;
    pewm_pkg::t_hist_ctrl w_ctrl_body;

    // trackers and output register
    pewm_pkg::t_code r_best_unmasked, n_best_unmasked;
    pewm_pkg::t_code r_best_masked,   n_best_masked;
    pewm_pkg::t_code r_word,          n_word;
    logic            r_out_valid,     n_out_valid;
    pewm_pkg::t_code w_poll_word;

    assign w_out_acc = r_out_valid && !i_stall;
    // a pending result blocks new transactions only while it is stalled
    assign o_stall   = r_out_valid && i_stall;
    assign w_in_acc  = i_valid && !o_stall;

    // poll selection: unmasked first, then masked, else zero
    assign w_poll_word = (r_best_unmasked != '0) ? r_best_unmasked : r_best_masked;

    // push on any nonzero poll; clear the body when falling back to a masked code
    always_comb begin
        w_ctrl_body.push  = w_in_acc && (i_op == pewm_pkg::OP_POLL) && (w_poll_word != '0);
        w_ctrl_body.clear = (r_best_unmasked == '0);
        w_ctrl_head.push  = w_ctrl_body.push;
        w_ctrl_head.clear = 1'b0;  // head always takes the word being sent
    end

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                pewm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctrl     (w_ctrl_head),
                    .i_shift_in (w_poll_word),
                    .i_probe    (i_error_id),
                    .o_entry    (w_entry[g]),
                    .o_match    (w_match[g])
                );
            end else begin : g_body
                pewm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctrl     (w_ctrl_body),
                    .i_shift_in (w_entry[g-1]),
                    .i_probe    (i_error_id),
                    .o_entry    (w_entry[g]),
                    .o_match    (w_match[g])
                );
            end
        end
    endgenerate

    assign w_hit = |w_match;

    always_comb begin
        n_best_unmasked = r_best_unmasked;
        n_best_masked   = r_best_masked;
        n_word          = r_word;
        n_out_valid     = r_out_valid && !w_out_acc;
        if (w_in_acc) begin
            unique case (i_op)
                pewm_pkg::OP_REPORT: begin
                    // code zero means none and leaves everything alone
                    if (i_error_id != '0) begin
                        if (w_hit) begin
                            if (r_best_masked == '0 || i_error_id < r_best_masked) begin
                                n_best_masked = i_error_id;
                            end
                        end else begin
                            if (r_best_unmasked == '0 || i_error_id < r_best_unmasked) begin
                                n_best_unmasked = i_error_id;
                            end
                        end
                    end
                end
                pewm_pkg::OP_POLL: begin
                    n_word      = w_poll_word;
                    n_out_valid = 1'b1;
                    if (w_poll_word != '0) begin
                        n_best_unmasked = '0;
                        n_best_masked   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_unmasked <= '0;
            r_best_masked   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_best_unmasked <= n_best_unmasked;
            r_best_masked   <= n_best_masked;
            r_out_valid     <= n_out_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid      = r_out_valid;
    assign o_telem_word = r_word;

endmodule : priority_error_word_with_recent_mask_unit

`default_nettype wire

// File: sv/pewm_checker.sv
// port-level checker for the priority error word unit, bound to the top level
// depends on pewm_pkg
`default_nettype none

module pewm_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_valid,
    input wire                        o_stall,
    input wire                        i_op,
    input wire                        o_valid,
    input wire                        i_stall,
    input wire [pewm_pkg::CODE_W-1:0] o_telem_word
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_telem_word))
        else $error("stalled result changed or dropped");

    // the input only stalls behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // every accepted poll yields a result in the next cycle
    a_poll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_op == pewm_pkg::OP_POLL |=> o_valid)
        else $error("poll transaction gave no result");

    // a report never creates a result
    a_report_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && i_valid && !o_stall && i_op == pewm_pkg::OP_REPORT |=> !o_valid)
        else $error("report transaction created a result");

endmodule : pewm_checker

bind priority_error_word_with_recent_mask_unit pewm_checker u_pewm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_telem_word (o_telem_word)
);

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for priority_error_word_with_recent_mask_unit
// predicts every error word from a shadow copy of the trackers and history;
// depends on pewm_pkg and the unit's top level only

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // must match the unit's default history depth
    localparam int unsigned DEPTH       = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_valid    = 1'b0;
    logic            i_op       = pewm_pkg::OP_REPORT;
    pewm_pkg::t_code i_error_id = '0;
    logic            i_stall    = 1'b0;
    logic            o_stall;
    logic            o_valid;
    pewm_pkg::t_code o_telem_word;

    priority_error_word_with_recent_mask_unit #(
        .HISTORY_DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_error_id  (i_error_id),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_telem_word(o_telem_word)
    );

    // shadow state of the unit: entry 0 of the history is the newest sent code
    pewm_pkg::t_code shadow_history [DEPTH];
    pewm_pkg::t_code shadow_unmasked = '0;
    pewm_pkg::t_code shadow_masked   = '0;

    // error words still owed by the unit, oldest first
    pewm_pkg::t_code pending_words [$];
    pewm_pkg::t_code owed_word;

    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned unmasked_words = 0;
    int unsigned masked_words   = 0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hard stop in case the unit hangs on either channel
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d error words still owed",
                     cycle_count, pending_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // every accepted output transaction is compared with the oldest owed word;
    // values read here are the ones from before the edge, so no race with the drivers
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("error word 0x%02h with none owed", o_telem_word));
            end else begin
                owed_word = pending_words.pop_front();
                if (o_telem_word !== owed_word)
                    report_mismatch($sformatf("telem_word got 0x%02h, want 0x%02h",
                                              o_telem_word, owed_word));
            end
        end
    end

    // advance the shadow state by one accepted transaction; a poll owes one word
    function automatic void predict_word(input logic op, input pewm_pkg::t_code code);
        bit              in_history;
        pewm_pkg::t_code word;
        if (op == pewm_pkg::OP_REPORT) begin
            // code zero means nothing to report
            if (code != '0) begin
                in_history = 1'b0;
                foreach (shadow_history[k])
                    if (shadow_history[k] == code) in_history = 1'b1;
                // only a strictly lower code replaces the tracked one
                if (!in_history) begin
                    if (shadow_unmasked == '0 || code < shadow_unmasked)
                        shadow_unmasked = code;
                end else if (shadow_masked == '0 || code < shadow_masked) begin
                    shadow_masked = code;
                end
            end
        end else begin
            word = '0;
            if (shadow_unmasked != '0) begin
                word = shadow_unmasked;
                unmasked_words++;
            end else if (shadow_masked != '0) begin
                // a masked code restarts the history from scratch
                word = shadow_masked;
                masked_words++;
                foreach (shadow_history[k]) shadow_history[k] = '0;
            end
            if (word != '0) begin
                for (int k = DEPTH - 1; k > 0; k--) shadow_history[k] = shadow_history[k - 1];
                shadow_history[0] = word;
                shadow_unmasked   = '0;
                shadow_masked     = '0;
            end
            pending_words.push_back(word);
        end
    endfunction

    // one input transaction; each cycle in front of it is idle with the sender's
    // idle chance, and valid stays high from one transaction to the next otherwise
    task automatic send_transaction(input logic op, input pewm_pkg::t_code code);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid    <= 1'b0;
            i_op       <= 1'($urandom_range(1));
            i_error_id <= pewm_pkg::t_code'($urandom_range(255));
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_error_id <= code;
        do @(posedge i_clk); while (o_stall);
        predict_word(op, code);
        items_sent++;
    endtask

    // drop valid and hold off until every owed word has come back
    task automatic rest_sender();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // mostly codes that collide with the history or with each other
    function automatic pewm_pkg::t_code pick_code();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return shadow_history[$urandom_range(DEPTH - 1)];
        else if (roll < 45)
            return '0;
        else if (roll < 75)
            return pewm_pkg::t_code'($urandom_range(24, 1));
        else
            return pewm_pkg::t_code'($urandom_range(255));
    endfunction

    // priority order, masking, equal codes, code zero and the empty poll
    task automatic test_priority_and_mask();
        send_transaction(pewm_pkg::OP_POLL,   8'hFF);   // nothing pending after reset
        send_transaction(pewm_pkg::OP_REPORT, 8'h00);   // zero code changes nothing
        send_transaction(pewm_pkg::OP_POLL,   8'h00);
        send_transaction(pewm_pkg::OP_REPORT, 8'hFF);
        send_transaction(pewm_pkg::OP_REPORT, 8'h01);   // lowest code wins
        send_transaction(pewm_pkg::OP_POLL,   8'hA5);
        send_transaction(pewm_pkg::OP_REPORT, 8'h01);   // already sent, so masked
        send_transaction(pewm_pkg::OP_REPORT, 8'hC8);   // unmasked beats a lower masked code
        send_transaction(pewm_pkg::OP_POLL,   8'h5A);
        send_transaction(pewm_pkg::OP_REPORT, 8'h01);
        send_transaction(pewm_pkg::OP_REPORT, 8'hC8);   // both masked now
        send_transaction(pewm_pkg::OP_POLL,   8'h00);   // masked word empties the history
        send_transaction(pewm_pkg::OP_REPORT, 8'hC8);   // unmasked again after the clear
        send_transaction(pewm_pkg::OP_REPORT, 8'hC8);   // equal code keeps the tracker
        send_transaction(pewm_pkg::OP_REPORT, 8'h80);
        send_transaction(pewm_pkg::OP_POLL,   8'h7F);
        send_transaction(pewm_pkg::OP_REPORT, 8'h7F);
        send_transaction(pewm_pkg::OP_POLL,   8'h80);
        send_transaction(pewm_pkg::OP_POLL,   8'hFF);   // trackers were cleared by the last word
    endtask

    // the oldest history entry drops out after DEPTH newer pushes
    task automatic test_history_aging();
        pewm_pkg::t_code base;
        base = pewm_pkg::t_code'($urandom_range(200, 30));
        // descending so each poll pushes a fresh code; base + DEPTH falls off the end
        for (int k = DEPTH; k >= 0; k--) begin
            send_transaction(pewm_pkg::OP_REPORT, base + pewm_pkg::t_code'(k));
            send_transaction(pewm_pkg::OP_POLL,   pewm_pkg::t_code'($urandom_range(255)));
        end
        // base is still masked, base + DEPTH has aged out and must win
        send_transaction(pewm_pkg::OP_REPORT, base);
        send_transaction(pewm_pkg::OP_REPORT, base + pewm_pkg::t_code'(DEPTH));
        send_transaction(pewm_pkg::OP_POLL,   pewm_pkg::t_code'($urandom_range(255)));
    endtask

    // bursts of reports closed by a poll; an empty burst gives back-to-back polls
    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(5);
            repeat (burst) begin
                send_transaction(pewm_pkg::OP_REPORT, pick_code());
                sent++;
            end
            send_transaction(pewm_pkg::OP_POLL, pewm_pkg::t_code'($urandom_range(255)));
            sent++;
        end
    endtask

    initial begin
        foreach (shadow_history[k]) shadow_history[k] = '0;

        // sender idles a third of the time, receiver about half
        tx_idle_pct = 33;
        rx_idle_pct = 53;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_priority_and_mask();
        test_random(125);
        rest_sender();

        // roles swapped
        tx_idle_pct = 53;
        rx_idle_pct = 33;
        test_history_aging();
        test_random(125);
        rest_sender();

        // full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(125);

        // let the last words drain, then watch for anything stray
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d transactions sent, %0d error words checked in %0d cycles",
                 items_sent, words_checked, cycle_count);
        $display("summary: %0d words from the unmasked tracker, %0d from the masked tracker",
                 unmasked_words, masked_words);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
